// ----- rtl/core/vertex_scale_rotate_translate_macros.svh -----
// Assertion macros for the vertex transform
`ifndef VERTEX_SCALE_ROTATE_TRANSLATE_MACROS_SVH
`define VERTEX_SCALE_ROTATE_TRANSLATE_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define VSRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset
`define VSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/vsrt_pkg.sv -----
// ----------------------------------------------------------------------------
// vsrt_pkg
// Constants, register indexes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`default_nettype none
package vsrt_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int TRIG_FRAC       = 16;
    localparam int ROM_BITS        = 6;
    localparam int TRIG_WIDTH      = TRIG_FRAC + 2;

    typedef enum logic [2:0] {
        REG_SCALE    = 3'd0,
        REG_ANGLE_XZ = 3'd1,
        REG_ANGLE_YZ = 3'd2,
        REG_ANGLE_XY = 3'd3,
        REG_SHIFT_X  = 3'd4,
        REG_SHIFT_Y  = 3'd5,
        REG_SHIFT_Z  = 3'd6
    } reg_index_t;

    // round(sin(k*pi/128) * 65536), k = 0..64
    function automatic logic [16:0] sin_rom(input logic [ROM_BITS:0] k);
        logic [16:0] r;
        case (k)
            7'd0: r = 17'd0;      7'd1: r = 17'd1608;   7'd2: r = 17'd3216;
            7'd3: r = 17'd4821;   7'd4: r = 17'd6424;   7'd5: r = 17'd8022;
            7'd6: r = 17'd9616;   7'd7: r = 17'd11204;  7'd8: r = 17'd12785;
            7'd9: r = 17'd14359;  7'd10: r = 17'd15924; 7'd11: r = 17'd17479;
            7'd12: r = 17'd19024; 7'd13: r = 17'd20557; 7'd14: r = 17'd22078;
            7'd15: r = 17'd23586; 7'd16: r = 17'd25080; 7'd17: r = 17'd26558;
            7'd18: r = 17'd28020; 7'd19: r = 17'd29466; 7'd20: r = 17'd30893;
            7'd21: r = 17'd32303; 7'd22: r = 17'd33692; 7'd23: r = 17'd35062;
            7'd24: r = 17'd36410; 7'd25: r = 17'd37736; 7'd26: r = 17'd39040;
            7'd27: r = 17'd40320; 7'd28: r = 17'd41576; 7'd29: r = 17'd42806;
            7'd30: r = 17'd44011; 7'd31: r = 17'd45190; 7'd32: r = 17'd46341;
            7'd33: r = 17'd47464; 7'd34: r = 17'd48559; 7'd35: r = 17'd49624;
            7'd36: r = 17'd50660; 7'd37: r = 17'd51665; 7'd38: r = 17'd52639;
            7'd39: r = 17'd53581; 7'd40: r = 17'd54491; 7'd41: r = 17'd55368;
            7'd42: r = 17'd56212; 7'd43: r = 17'd57022; 7'd44: r = 17'd57798;
            7'd45: r = 17'd58538; 7'd46: r = 17'd59244; 7'd47: r = 17'd59914;
            7'd48: r = 17'd60547; 7'd49: r = 17'd61145; 7'd50: r = 17'd61705;
            7'd51: r = 17'd62228; 7'd52: r = 17'd62714; 7'd53: r = 17'd63162;
            7'd54: r = 17'd63572; 7'd55: r = 17'd63944; 7'd56: r = 17'd64277;
            7'd57: r = 17'd64571; 7'd58: r = 17'd64827; 7'd59: r = 17'd65043;
            7'd60: r = 17'd65220; 7'd61: r = 17'd65358; 7'd62: r = 17'd65457;
            7'd63: r = 17'd65516; 7'd64: r = 17'd65536;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/vertex_scale_rotate_translate.sv -----
// ----------------------------------------------------------------------------
// vertex_scale_rotate_translate
// Scale, three plane rotations and translation of one vertex per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries in_x, in_y, in_z; output channel
// out_valid/out_stall carries out_x, out_y, out_z. A transfer happens when
// valid is high and stall low. Config is a plain write port (cfg_we,
// cfg_index, cfg_wdata); the user writes it only while the pipe is empty,
// which the block does not enforce. Nine register stages; throughput is
// one vertex per cycle while the output is not stalled. Pipe: scale
// multiply, scale round, then three rotations of two stages each (multiply,
// sum/round), then translate.
// The whole pipe advances together whenever the output stage is free or
// not holding valid data, so a stall freezes every stage: nothing is lost
// or repeated. in_stall is simply the output held and stalled.
// Reset clears all valid bits and restores scale 1.0, zero angles and
// zero shifts. Sine/cosine are computed continuously from the angle
// registers, registered, and steady while the angles are unchanged.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_scale_rotate_translate_macros.svh"
module vertex_scale_rotate_translate
    import vsrt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire  [2:0]                    cfg_index,
    input  wire  [COORD_WIDTH-1:0]        cfg_wdata,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire  signed [COORD_WIDTH-1:0] in_x,
    input  wire  signed [COORD_WIDTH-1:0] in_y,
    input  wire  signed [COORD_WIDTH-1:0] in_z,
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z
);
    localparam int STAGES = 9;
    localparam int MW = 2 * COORD_WIDTH;
    localparam logic signed [MW:0] MAXV = (MW+1)'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [MW:0] MINV = -MAXV - 1;

    logic signed [COORD_WIDTH-1:0] scale_reg, shx_reg, shy_reg, shz_reg;
    logic [ANGLE_WIDTH-1:0]        axz_reg, ayz_reg, axy_reg;
    logic signed [TRIG_WIDTH-1:0]  s1, c1, s2, c2, s3, c3;
    logic [STAGES-1:0]             vld_reg;
    logic                          adv;

    logic signed [MW-1:0]          px_reg, py_reg, pz_reg;
    logic signed [COORD_WIDTH-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [COORD_WIDTH-1:0] r1u, r1w, r1p, r2u, r2w, r2p, r3u, r3w, r3p;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= COORD_WIDTH'(1 << FRAC_BITS);
            axz_reg <= '0; ayz_reg <= '0; axy_reg <= '0;
            shx_reg <= '0; shy_reg <= '0; shz_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE:    scale_reg <= cfg_wdata;
                REG_ANGLE_XZ: axz_reg   <= cfg_wdata[ANGLE_WIDTH-1:0];
                REG_ANGLE_YZ: ayz_reg   <= cfg_wdata[ANGLE_WIDTH-1:0];
                REG_ANGLE_XY: axy_reg   <= cfg_wdata[ANGLE_WIDTH-1:0];
                REG_SHIFT_X:  shx_reg   <= cfg_wdata;
                REG_SHIFT_Y:  shy_reg   <= cfg_wdata;
                REG_SHIFT_Z:  shz_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vsrt_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_xz (.clk, .phase(axz_reg), .sin_val(s1), .cos_val(c1));
    vsrt_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_yz (.clk, .phase(ayz_reg), .sin_val(s2), .cos_val(c2));
    vsrt_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_xy (.clk, .phase(axy_reg), .sin_val(s3), .cos_val(c3));

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
    end

    function automatic logic signed [COORD_WIDTH-1:0] rnd_scale(input logic signed [MW-1:0] v);
        logic signed [MW:0] t;
        t = ((MW+1)'(v) + (MW+1)'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (t > MAXV) return MAXV[COORD_WIDTH-1:0];
        if (t < MINV) return MINV[COORD_WIDTH-1:0];
        return t[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_add(
        input logic signed [COORD_WIDTH-1:0] a, input logic signed [COORD_WIDTH-1:0] b);
        logic signed [COORD_WIDTH:0] t;
        t = (COORD_WIDTH+1)'(a) + (COORD_WIDTH+1)'(b);
        if (t[COORD_WIDTH] != t[COORD_WIDTH-1])
            return t[COORD_WIDTH] ? MINV[COORD_WIDTH-1:0] : MAXV[COORD_WIDTH-1:0];
        return t[COORD_WIDTH-1:0];
    endfunction

    // scale: multiply, then round and clamp
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= MW'(in_x) * MW'(scale_reg);
            py_reg <= MW'(in_y) * MW'(scale_reg);
            pz_reg <= MW'(in_z) * MW'(scale_reg);
            sx_reg <= rnd_scale(px_reg);
            sy_reg <= rnd_scale(py_reg);
            sz_reg <= rnd_scale(pz_reg);
        end
    end

    // x-z plane, then y-z, then x-y
    vsrt_rot #(.COORD_WIDTH(COORD_WIDTH)) u_rot_xz (.clk, .en(adv),
        .u_in(sx_reg), .w_in(sz_reg), .p_in(sy_reg), .s(s1), .c(c1),
        .u_out(r1u), .w_out(r1w), .p_out(r1p));
    vsrt_rot #(.COORD_WIDTH(COORD_WIDTH)) u_rot_yz (.clk, .en(adv),
        .u_in(r1p), .w_in(r1w), .p_in(r1u), .s(s2), .c(c2),
        .u_out(r2u), .w_out(r2w), .p_out(r2p));
    vsrt_rot #(.COORD_WIDTH(COORD_WIDTH)) u_rot_xy (.clk, .en(adv),
        .u_in(r2p), .w_in(r2u), .p_in(r2w), .s(s3), .c(c3),
        .u_out(r3u), .w_out(r3w), .p_out(r3p));

    // translate into the output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x <= sat_add(r3u, shx_reg);
            out_y <= sat_add(r3w, shy_reg);
            out_z <= sat_add(r3p, shz_reg);
        end
    end

    assign out_valid = vld_reg[STAGES-1];

    `VSRT_ASSERT_IMPL(a_stall_only_when_held, clk, rst_n, in_stall, out_valid && out_stall)
    `VSRT_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_x))
    `VSRT_ASSERT_NEXT(a_valid_moves, clk, rst_n, !in_stall && in_valid, vld_reg[0])
endmodule
`default_nettype wire

// ----- rtl/core/vsrt_trig.sv -----
// ----------------------------------------------------------------------------
// vsrt_trig
// Sine and cosine of one phase, table lookup plus interpolation, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module vsrt_trig
    import vsrt_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  wire                           clk,
    input  wire  [ANGLE_WIDTH-1:0]        phase,
    output logic signed [TRIG_WIDTH-1:0]  sin_val,
    output logic signed [TRIG_WIDTH-1:0]  cos_val
);
    localparam int SH = ANGLE_WIDTH - 2 - ROM_BITS;
    localparam int RW = ANGLE_WIDTH - 2;

    function automatic logic signed [TRIG_WIDTH-1:0] sin_of(input logic [ANGLE_WIDTH-1:0] p);
        logic [1:0]          q;
        logic [RW:0]         r;
        logic [RW:0]         f;
        logic [ROM_BITS:0]   idx;
        logic [SH-1:0]       rem;
        logic [16:0]         a;
        logic [16:0]         b;
        logic [16+SH:0]      prod;
        logic [16:0]         m;
        q   = p[ANGLE_WIDTH-1 -: 2];
        r   = {1'b0, p[RW-1:0]};
        f   = q[0] ? ((RW+1)'(1) << RW) - r : r;
        idx = f[RW:SH];
        rem = f[SH-1:0];
        if (idx[ROM_BITS]) begin
            m = sin_rom(idx);
        end else begin
            a    = sin_rom(idx);
            b    = sin_rom(idx + 1'b1);
            prod = (17+SH)'(b - a) * (17+SH)'(rem) + ((17+SH)'(1) << (SH - 1));
            m    = a + 17'(prod >> SH);
        end
        return q[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    always_ff @(posedge clk)
    begin
        sin_val <= sin_of(phase);
        cos_val <= sin_of(phase + (ANGLE_WIDTH)'(1 << (ANGLE_WIDTH - 2)));
    end
endmodule
`default_nettype wire

// ----- rtl/core/vsrt_rot.sv -----
// ----------------------------------------------------------------------------
// vsrt_rot
// One plane rotation: products registered, then sum, round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none
module vsrt_rot
    import vsrt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire                           clk,
    input  wire                           en,
    input  wire  signed [COORD_WIDTH-1:0] u_in,
    input  wire  signed [COORD_WIDTH-1:0] w_in,
    input  wire  signed [COORD_WIDTH-1:0] p_in,
    input  wire  signed [TRIG_WIDTH-1:0]  s,
    input  wire  signed [TRIG_WIDTH-1:0]  c,
    output logic signed [COORD_WIDTH-1:0] u_out,
    output logic signed [COORD_WIDTH-1:0] w_out,
    output logic signed [COORD_WIDTH-1:0] p_out
);
    localparam int PW = COORD_WIDTH + TRIG_WIDTH;
    localparam logic signed [PW:0] MAXV = (PW+1)'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [PW:0] MINV = -MAXV - 1;

    logic signed [PW-1:0]        uc_reg, ws_reg, us_reg, wc_reg;
    logic signed [COORD_WIDTH-1:0] p_mid_reg;

    function automatic logic signed [COORD_WIDTH-1:0] rnd(input logic signed [PW:0] v);
        logic signed [PW:0] t;
        t = (v + (PW+1)'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        if (t > MAXV) return MAXV[COORD_WIDTH-1:0];
        if (t < MINV) return MINV[COORD_WIDTH-1:0];
        return t[COORD_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uc_reg    <= PW'(u_in) * PW'(c);
            ws_reg    <= PW'(w_in) * PW'(s);
            us_reg    <= PW'(u_in) * PW'(s);
            wc_reg    <= PW'(w_in) * PW'(c);
            p_mid_reg <= p_in;
            u_out <= rnd((PW+1)'(uc_reg) - (PW+1)'(ws_reg));
            w_out <= rnd((PW+1)'(us_reg) + (PW+1)'(wc_reg));
            p_out <= p_mid_reg;
        end
    end
endmodule
`default_nettype wire

// ----- test/vertex_scale_rotate_translate_tb.sv -----
// ----------------------------------------------------------------------------
// vertex_scale_rotate_translate_tb
// Self-checking bench for the vertex scale/rotate/translate pipe.
// Vertices stream in through a bursty sender and results are drained through
// a receiver that stalls on its own pattern. A scoreboard class works out the
// expected vertex for each accepted transfer, then checks results in order.
// The configuration changes between phases, only while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module vertex_scale_rotate_translate_tb;
    import vsrt_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;   // no register here; write ignored
    localparam int PIPE_DEPTH = 9;
    localparam int SINE_SHIFT = 8;              // angle bits below the table index

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vertex_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers and the sine table, queue of
    // expected vertices in transfer order.
    // ------------------------------------------------------------------------
    class vertex_scoreboard;
        logic signed [31:0] scale_q16;
        logic [15:0]        ang_xz, ang_yz, ang_xy;
        logic signed [31:0] off_x, off_y, off_z;
        longint unsigned    sine_tab[65];
        vertex_t            expected_q[$];
        int                 errors;

        function new();
            longint unsigned xr, x2, term;
            longint          acc;
            scale_q16 = 32'sh0001_0000;
            ang_xz = '0; ang_yz = '0; ang_xy = '0;
            off_x = '0; off_y = '0; off_z = '0;
            errors = 0;
            // sin(k*pi/128) in Q16, from a Q30 Taylor series
            for (int k = 0; k <= 64; k++)
            begin
                xr   = (longint'(k) * 64'd3373259426 + 64'd64) >> 7;
                x2   = (xr * xr) >> 30;
                term = xr;
                acc  = longint'(xr);
                for (int n = 1; n <= 6; n++)
                begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        acc -= longint'(term);
                    else
                        acc += longint'(term);
                end
                if (acc < 0)
                    acc = 0;
                sine_tab[k] = (longint'(acc) + 8192) >> 14;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_SCALE:    scale_q16 = d;
                REG_ANGLE_XZ: ang_xz    = d[15:0];
                REG_ANGLE_YZ: ang_yz    = d[15:0];
                REG_ANGLE_XY: ang_xy    = d[15:0];
                REG_SHIFT_X:  off_x     = d;
                REG_SHIFT_Y:  off_y     = d;
                REG_SHIFT_Z:  off_z     = d;
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // shift right with rounding half up, then clamp
        function longint round_sat(longint v, int sh);
            return sat32((v + (64'sd1 <<< (sh - 1))) >>> sh);
        endfunction

        function longint quarter_wave(longint unsigned r);
            longint unsigned idx, rem, a, b;
            idx = r >> SINE_SHIFT;
            rem = r & ((64'd1 << SINE_SHIFT) - 1);
            if (idx >= 64)
                return longint'(sine_tab[64]);
            a = sine_tab[idx];
            b = sine_tab[idx + 1];
            return longint'(a + (((b - a) * rem + (64'd1 << (SINE_SHIFT - 1))) >> SINE_SHIFT));
        endfunction

        function longint sine(logic [15:0] p);
            logic [1:0]      quad;
            longint unsigned r;
            longint          m;
            quad = p[15:14];
            r    = 64'(p[13:0]);
            m    = quad[0] ? quarter_wave(64'd16384 - r) : quarter_wave(r);
            return quad[1] ? -m : m;
        endfunction

        // (u, w) -> (u*c - w*s, u*s + w*c)
        function void turn(input longint u, input longint w, input logic [15:0] p,
                           output longint nu, output longint nw);
            longint s, c;
            logic [15:0] pc;
            pc = p + 16'h4000;
            s  = sine(p);
            c  = sine(pc);
            nu = round_sat(u * c - w * s, 16);
            nw = round_sat(u * s + w * c, 16);
        endfunction

        function void note_input(vertex_t v);
            longint  x, y, z, t0, t1;
            vertex_t e;
            x = round_sat(longint'(v.x) * longint'(scale_q16), 16);
            y = round_sat(longint'(v.y) * longint'(scale_q16), 16);
            z = round_sat(longint'(v.z) * longint'(scale_q16), 16);
            turn(x, z, ang_xz, t0, t1); x = t0; z = t1;
            turn(y, z, ang_yz, t0, t1); y = t0; z = t1;
            turn(x, y, ang_xy, t0, t1); x = t0; y = t1;
            e.x = 32'(sat32(x + longint'(off_x)));
            e.y = 32'(sat32(y + longint'(off_y)));
            e.z = 32'(sat32(z + longint'(off_z)));
            expected_q.push_back(e);
        endfunction

        function void check_result(vertex_t a);
            vertex_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, a.x, a.y, a.z);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.x !== e.x)
            begin
                $display("%0t: out_x expected %0d actual %0d", $time, e.x, a.x);
                errors++;
            end
            if (a.y !== e.y)
            begin
                $display("%0t: out_y expected %0d actual %0d", $time, e.y, a.y);
                errors++;
            end
            if (a.z !== e.z)
            begin
                $display("%0t: out_z expected %0d actual %0d", $time, e.z, a.z);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] in_x, in_y, in_z;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] out_x, out_y, out_z;

    vertex_scoreboard sb;
    int burst_left;     // transfers left in the current sender burst

    vertex_scale_rotate_translate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the pipe hangs
    initial
    begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stalls on a pattern of its own. Modes change every so often:
    // never stall, stall now and then, stall most of the time.
    // ------------------------------------------------------------------------
    initial
    begin
        int mode_left;
        int mode;
        vertex_t got;
        mode_left = 0;
        mode      = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.x = out_x; got.y = out_y; got.z = out_z;
                sb.check_result(got);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // drop valid for a random gap (or none) when the burst is spent
    task automatic burst_gap();
        if (burst_left > 0)
            return;
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // one vertex; returns once the transfer has happened
    task automatic send_vertex(vertex_t v);
        burst_gap();
        in_valid <= 1'b1;
        in_x     <= v.x;
        in_y     <= v.y;
        in_z     <= v.z;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(v);
        burst_left--;
    endtask

    // let every result drain, then wait longer than the pipe depth for the pipe to empty
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
        cfg_we    <= 1'b0;
    endtask

    // modest coordinates half the time, some full range, some extremes
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0, 1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2:    return $signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000;
            3:    return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 3) << 14);          // quadrant boundaries
            1: return $urandom;                                 // stray high bits too
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic logic [31:0] pick_shift();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic send_xyz(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
        vertex_t v;
        v.x = x; v.y = y; v.z = z;
        send_vertex(v);
    endtask

    initial
    begin
        vertex_t v;
        sb         = new();
        burst_left = 0;
        rst_n      = 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_SCALE;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        in_x      <= '0;
        in_y      <= '0;
        in_z      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: identity transform, extreme coordinates pass through
        send_xyz(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
        send_xyz(32'sh1, -32'sh1, 32'sh0001_0000);
        send_xyz(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        drain_pipe();

        // a write to the unused index must change nothing
        write_cfg(REG_UNUSED, 32'hDEAD_BEEF);
        send_xyz(32'sh0003_0000, -32'sh0002_8000, 32'sh1234_5678);
        drain_pipe();

        // quarter, half and three-quarter turns, stray high bits on two writes
        write_cfg(REG_ANGLE_XZ, 32'hFFFF_4000);
        write_cfg(REG_ANGLE_YZ, 32'h0001_8000);
        write_cfg(REG_ANGLE_XY, 32'h0000_C000);
        send_xyz(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        send_xyz(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1);
        drain_pipe();

        // extreme scale and shifts: saturation at each stage
        write_cfg(REG_SCALE,   32'h7FFF_FFFF);
        write_cfg(REG_ANGLE_XZ, 32'h0000_FFFF);
        write_cfg(REG_SHIFT_X, 32'h7FFF_FFFF);
        write_cfg(REG_SHIFT_Y, 32'h8000_0000);
        write_cfg(REG_SHIFT_Z, 32'h7FFF_FFFF);
        send_xyz(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1);
        send_xyz(32'sh0, 32'sh0, 32'sh0);
        send_xyz(-32'sh1, 32'sh1, 32'sh8000);
        drain_pipe();
        write_cfg(REG_SCALE, 32'h8000_0000);
        write_cfg(REG_SHIFT_X, 32'h8000_0000);
        write_cfg(REG_SHIFT_Y, 32'h7FFF_FFFF);
        write_cfg(REG_SHIFT_Z, 32'h8000_0000);
        send_xyz(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh0001_0000);
        send_xyz(32'sh1, -32'sh1, 32'sh0);
        drain_pipe();

        // random phases, each under a fresh configuration
        for (int phase = 0; phase < 10; phase++)
        begin
            write_cfg(REG_SCALE,    pick_scale());
            write_cfg(REG_ANGLE_XZ, pick_angle());
            write_cfg(REG_ANGLE_YZ, pick_angle());
            write_cfg(REG_ANGLE_XY, pick_angle());
            write_cfg(REG_SHIFT_X,  pick_shift());
            write_cfg(REG_SHIFT_Y,  pick_shift());
            write_cfg(REG_SHIFT_Z,  pick_shift());
            if ($urandom_range(0, 3) == 0)
                write_cfg(REG_UNUSED, $urandom);
            repeat (190)
            begin
                v.x = pick_coord();
                v.y = pick_coord();
                v.z = pick_coord();
                send_vertex(v);
            end
            drain_pipe();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/vsrt_pkg.sv
rtl/core/vsrt_trig.sv
rtl/core/vsrt_rot.sv
rtl/core/vertex_scale_rotate_translate.sv
test/vertex_scale_rotate_translate_tb.sv
